>>> design/otwr_pkg.sv
`default_nettype none

package otwr_pkg;

    localparam int unsigned CountW   = 10;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 10;
    localparam int unsigned TempW    = 7;

    localparam logic [7:0] CmdSkipRom  = 8'hCC;
    localparam logic [7:0] CmdConvert  = 8'h44;
    localparam logic [7:0] CmdReadPad  = 8'hBE;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_TAIL = 3'd3,
        PH_SLOT_LOW = 3'd4,
        PH_WR_BODY  = 3'd5,
        PH_RD_WAIT  = 3'd6,
        PH_RD_TAIL  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        STEP_SKIP1    = 3'd0,
        STEP_CONVERT  = 3'd1,
        STEP_POLL     = 3'd2,
        STEP_SKIP2    = 3'd3,
        STEP_READ_CMD = 3'd4,
        STEP_READ_LO  = 3'd5,
        STEP_READ_HI  = 3'd6
    } step_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RESET_LOW   = 3'd0,
        REG_PRES_WAIT   = 3'd1,
        REG_RESET_TAIL  = 3'd2,
        REG_WR_SLOT     = 3'd3,
        REG_RD_SAMPLE   = 3'd4,
        REG_RD_TAIL     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic start_req;
        logic line_level;
    } in_item_t;

    typedef struct packed {
        logic             drive_low;
        logic             busy_res;
        logic             done_res;
        logic             no_device;
        logic [TempW-1:0] temperature;
    } out_item_t;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_wait;
        logic [9:0] reset_tail;
        logic [7:0] write_slot_time;
        logic [5:0] read_sample_time;
        logic [7:0] read_tail;
    } cfg_t;

    function automatic logic [7:0] cmd_byte(input step_t s);
        logic [7:0] b;
        unique case (s)
            STEP_SKIP1:    b = CmdSkipRom;
            STEP_CONVERT:  b = CmdConvert;
            STEP_SKIP2:    b = CmdSkipRom;
            STEP_READ_CMD: b = CmdReadPad;
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic is_write_step(input step_t s);
        return (s == STEP_SKIP1) || (s == STEP_CONVERT) ||
               (s == STEP_SKIP2) || (s == STEP_READ_CMD);
    endfunction

    // zero duration acts as one microsecond
    function automatic logic [CountW-1:0] span(input logic [CountW-1:0] v);
        return (v == '0) ? CountW'(1) : v;
    endfunction

endpackage

`default_nettype wire

>>> design/otwr_cfg.sv
`default_nettype none

module otwr_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [otwr_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [otwr_pkg::CfgDataW-1:0]   cfg_data,
    output otwr_pkg::cfg_t                       cfg
);

    otwr_pkg::cfg_t cfg_reg;
    otwr_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (otwr_pkg::cfg_reg_t'(cfg_index))
                otwr_pkg::REG_RESET_LOW:  cfg_next.reset_low_time   = cfg_data;
                otwr_pkg::REG_PRES_WAIT:  cfg_next.presence_wait    = cfg_data[7:0];
                otwr_pkg::REG_RESET_TAIL: cfg_next.reset_tail       = cfg_data;
                otwr_pkg::REG_WR_SLOT:    cfg_next.write_slot_time  = cfg_data[7:0];
                otwr_pkg::REG_RD_SAMPLE:  cfg_next.read_sample_time = cfg_data[5:0];
                otwr_pkg::REG_RD_TAIL:    cfg_next.read_tail        = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_time   <= 10'd480;
            cfg_reg.presence_wait    <= 8'd100;
            cfg_reg.reset_tail       <= 10'd380;
            cfg_reg.write_slot_time  <= 8'd60;
            cfg_reg.read_sample_time <= 6'd14;
            cfg_reg.read_tail        <= 8'd45;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> design/otwr_core.sv
`default_nettype none

module otwr_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire otwr_pkg::in_item_t  in_item,
    input  wire otwr_pkg::cfg_t      cfg,
    output otwr_pkg::out_item_t      out_item
);

    localparam int unsigned CW = otwr_pkg::CountW;

    otwr_pkg::phase_t          phase_reg, phase_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [2:0]                bit_reg, bit_next;
    otwr_pkg::step_t           step_reg, step_next;
    logic [7:0]                shift_reg, shift_next;
    logic [7:0]                low_reg, low_next;
    logic [otwr_pkg::TempW-1:0] temp_reg, temp_next;
    logic                      sample_reg, sample_next;

    logic                      fin;
    logic                      fin_report;
    logic                      fin_error;

    logic [CW-1:0] inc;
    logic [CW-1:0] lim_rst_low, lim_pres, lim_rst_tail, lim_wr, lim_rd_smp, lim_rd_tail;

    assign inc          = count_reg + CW'(1);
    assign lim_rst_low  = otwr_pkg::span(cfg.reset_low_time);
    assign lim_pres     = otwr_pkg::span({2'b00, cfg.presence_wait});
    assign lim_rst_tail = otwr_pkg::span(cfg.reset_tail);
    assign lim_wr       = otwr_pkg::span({2'b00, cfg.write_slot_time});
    assign lim_rd_smp   = otwr_pkg::span({4'b0000, cfg.read_sample_time});
    assign lim_rd_tail  = otwr_pkg::span({2'b00, cfg.read_tail});

    // next state
    always_comb begin
        logic       slot_end;
        logic [2:0] bit_inc;
        logic [7:0] shifted;
        otwr_pkg::step_t go_step;
        logic       go;

        phase_next  = phase_reg;
        count_next  = count_reg;
        bit_next    = bit_reg;
        step_next   = step_reg;
        shift_next  = shift_reg;
        low_next    = low_reg;
        temp_next   = temp_reg;
        sample_next = sample_reg;
        fin         = 1'b0;
        fin_report  = 1'b0;
        fin_error   = 1'b0;
        slot_end    = 1'b0;
        go          = 1'b0;
        go_step     = otwr_pkg::STEP_SKIP1;
        bit_inc     = bit_reg + 3'd1;

        unique case (phase_reg)
            otwr_pkg::PH_IDLE: begin
                if (in_item.start_req) begin
                    step_next  = otwr_pkg::STEP_SKIP1;
                    phase_next = otwr_pkg::PH_RST_LOW;
                    count_next = '0;
                end
            end
            otwr_pkg::PH_RST_LOW: begin
                count_next = inc;
                if (inc >= lim_rst_low) begin
                    phase_next = otwr_pkg::PH_RST_WAIT;
                    count_next = '0;
                end
            end
            otwr_pkg::PH_RST_WAIT: begin
                count_next = inc;
                if (inc >= lim_pres) begin
                    phase_next = otwr_pkg::PH_RST_TAIL;
                    count_next = '0;
                end
            end
            otwr_pkg::PH_RST_TAIL: begin
                if (count_reg == '0) begin
                    sample_next = in_item.line_level;
                end
                count_next = inc;
                if (inc >= lim_rst_tail) begin
                    if (step_reg == otwr_pkg::STEP_SKIP1) begin
                        if (sample_next) begin
                            fin        = 1'b1;
                            fin_report = 1'b1;
                            fin_error  = 1'b1;
                        end else begin
                            go      = 1'b1;
                            go_step = otwr_pkg::STEP_SKIP1;
                        end
                    end else begin
                        go      = 1'b1;
                        go_step = otwr_pkg::STEP_SKIP2;
                    end
                end
            end
            otwr_pkg::PH_SLOT_LOW: begin
                phase_next = otwr_pkg::is_write_step(step_reg) ? otwr_pkg::PH_WR_BODY
                                                              : otwr_pkg::PH_RD_WAIT;
                count_next = '0;
            end
            otwr_pkg::PH_WR_BODY: begin
                count_next = inc;
                slot_end   = (inc >= lim_wr);
            end
            otwr_pkg::PH_RD_WAIT: begin
                count_next = inc;
                if (inc >= lim_rd_smp) begin
                    phase_next = otwr_pkg::PH_RD_TAIL;
                    count_next = '0;
                end
            end
            otwr_pkg::PH_RD_TAIL: begin
                if (count_reg == '0) begin
                    sample_next = in_item.line_level;
                end
                count_next = inc;
                slot_end   = (inc >= lim_rd_tail);
            end
        endcase

        shifted = {sample_next, shift_reg[7:1]};

        if (slot_end) begin
            if (otwr_pkg::is_write_step(step_reg)) begin
                shift_next = {1'b0, shift_reg[7:1]};
                if (bit_inc != 3'd0) begin
                    bit_next   = bit_inc;
                    phase_next = otwr_pkg::PH_SLOT_LOW;
                    count_next = '0;
                end else begin
                    go = 1'b1;
                    unique case (step_reg)
                        otwr_pkg::STEP_SKIP1:   go_step = otwr_pkg::STEP_CONVERT;
                        otwr_pkg::STEP_CONVERT: go_step = otwr_pkg::STEP_POLL;
                        otwr_pkg::STEP_SKIP2:   go_step = otwr_pkg::STEP_READ_CMD;
                        default:                go_step = otwr_pkg::STEP_READ_LO;
                    endcase
                end
            end else if (step_reg == otwr_pkg::STEP_POLL) begin
                count_next = '0;
                if (sample_next) begin
                    step_next  = otwr_pkg::STEP_SKIP2;
                    phase_next = otwr_pkg::PH_RST_LOW;
                end else begin
                    phase_next = otwr_pkg::PH_SLOT_LOW;
                end
            end else if (step_reg == otwr_pkg::STEP_READ_LO ||
                         step_reg == otwr_pkg::STEP_READ_HI) begin
                shift_next = shifted;
                bit_next   = bit_inc;
                if (bit_inc != 3'd0) begin
                    phase_next = otwr_pkg::PH_SLOT_LOW;
                    count_next = '0;
                end else if (step_reg == otwr_pkg::STEP_READ_LO) begin
                    low_next = shifted;
                    go       = 1'b1;
                    go_step  = otwr_pkg::STEP_READ_HI;
                end else begin
                    // only the low byte reaches the 7-bit result
                    temp_next  = low_reg[7:1];
                    fin        = 1'b1;
                    fin_report = 1'b1;
                end
            end else begin
                fin = 1'b1;
            end
        end

        if (go) begin
            step_next  = go_step;
            bit_next   = 3'd0;
            shift_next = otwr_pkg::cmd_byte(go_step);
            phase_next = otwr_pkg::PH_SLOT_LOW;
            count_next = '0;
        end

        if (fin) begin
            phase_next = otwr_pkg::PH_IDLE;
            count_next = '0;
        end
    end

    // result
    always_comb begin
        out_item = '0;
        unique case (phase_reg)
            otwr_pkg::PH_RST_LOW,
            otwr_pkg::PH_SLOT_LOW: out_item.drive_low = 1'b1;
            otwr_pkg::PH_WR_BODY:  out_item.drive_low = ~shift_reg[0];
            default:               out_item.drive_low = 1'b0;
        endcase
        if (phase_reg == otwr_pkg::PH_IDLE) begin
            out_item.busy_res = in_item.start_req;
        end else begin
            out_item.busy_res = ~fin;
        end
        out_item.done_res    = fin_report;
        out_item.no_device   = fin_report & fin_error;
        out_item.temperature = (fin_report && !fin_error) ? temp_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= otwr_pkg::PH_IDLE;
            count_reg  <= '0;
            bit_reg    <= '0;
            step_reg   <= otwr_pkg::STEP_SKIP1;
            shift_reg  <= '0;
            low_reg    <= '0;
            temp_reg   <= '0;
            sample_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            bit_reg    <= bit_next;
            step_reg   <= step_next;
            shift_reg  <= shift_next;
            low_reg    <= low_next;
            temp_reg   <= temp_next;
            sample_reg <= sample_next;
        end
    end

endmodule

`default_nettype wire

>>> design/otwr_out.sv
`default_nettype none

module otwr_out (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    output logic                      push_ready,
    input  wire otwr_pkg::out_item_t  push_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output otwr_pkg::out_item_t       m_item
);

    otwr_pkg::out_item_t main_reg, main_next;
    otwr_pkg::out_item_t skid_reg, skid_next;
    logic                main_valid_reg, main_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic                pop;

    assign pop        = main_valid_reg & m_ready;
    assign push_ready = ~skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_item     = main_reg;

    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_item;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_item;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

>>> design/one_wire_temperature_reader_top.sv
// channel   ports                              payload
// s_        s_valid s_ready s_item             start_req, line_level (one microsecond tick)
// m_        m_valid m_ready m_item             drive_low, busy_res, done_res, no_device,
//                                              temperature
// cfg_      cfg_valid cfg_ready cfg_index      cfg_data, six timing registers
//
// one tick is taken per clock while s_ready is high; its result is registered in the output buffer
// a two-entry output buffer keeps s_ready high while one result waits on m_ready
// s_ready drops only when both entries are full
// aresetn is synchronous, active low; timing registers return to their defaults
// cfg_ready is always high
`default_nettype none

module one_wire_temperature_reader_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire otwr_pkg::in_item_t              s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output otwr_pkg::out_item_t                  m_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [otwr_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [otwr_pkg::CfgDataW-1:0]   cfg_data
);

    otwr_pkg::cfg_t      cfg;
    otwr_pkg::out_item_t result;
    logic                accept;

    assign accept = s_valid & s_ready;

    otwr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    otwr_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (accept),
        .in_item  (s_item),
        .cfg      (cfg),
        .out_item (result)
    );

    otwr_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_ready (s_ready),
        .push_item  (result),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

`default_nettype wire
